>>> src/btps_pkg.sv
// ----------------------------------------------------------------------------
// btps_pkg
// Shared constants for the beep tone PWM setup core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btps_pkg;

    localparam int DURATION_BITS = 24;

    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 24;
    localparam int VOL_W     = 8;
    localparam int ELAPSED_W = 16;
    localparam int CLOCK_W   = 24;
    localparam int RELOAD_W  = 20;
    localparam int COMPARE_W = 18;

    localparam int DIVISOR_W = 14;
    localparam int PROD_W    = 27;
    localparam int VCLAMP_W  = 7;
    localparam int CNT_W     = 5;

    localparam logic [FREQ_W-1:0]    FREQ_MIN    = 16'd20;
    localparam logic [FREQ_W-1:0]    FREQ_MAX    = 16'd16000;
    localparam logic [VOL_W-1:0]     VOL_MAX     = 8'd100;
    localparam logic [DIVISOR_W-1:0] DUTY_DIV    = 14'd333;
    localparam logic [CLOCK_W-1:0]   RESET_CLOCK = 24'd1000000;
    localparam logic [RELOAD_W-1:0]  RESET_RELOAD = 20'd1000;

    localparam logic OP_BEEP = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic REG_TONE_CLOCK = 1'b0;

endpackage

`default_nettype wire

>>> src/beep_tone_pwm_setup_core.sv
// ----------------------------------------------------------------------------
// beep_tone_pwm_setup_core
// Tone beeper control: PWM reload/compare setup and beep countdown.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word
//  s_axis    in   tuser: opcode; tdata: frequency_hz, duration_ms,
//                 volume_percent, elapsed_ms
//  m_axis    out  tdata: reload_value, compare_value, tone_active
//  apb       in   register 0 at 0x0: tone_clock_hz (24 bits)
//
//  Nonzero-duration beep: 24 divider steps for the reload, one multiply,
//  27 divider steps by 333, then the output step; the next word is taken
//  after the output step. Tick or zero-duration beep: output step only.
//  Reset loads reload 1000, compare 0, no remaining time, clock 1 MHz.
//  A new word is taken while a finished result still waits on m_axis; the
//  next result then holds in the output step until m_axis takes the first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module beep_tone_pwm_setup_core
    import btps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] frequency_hz, [39:16] duration_ms, [47:40] volume_percent,
    // [63:48] elapsed_ms
    input  wire logic [63:0] s_axis_tdata,
    // [0] opcode
    input  wire logic        s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [19:0] reload_value, [37:20] compare_value, [38] tone_active, [39] zero
    output logic      [39:0] m_axis_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DCMP = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [32:0] DUR_MAX = (33'd1 << DURATION_BITS) - 33'd1;

    logic [2:0]               state_reg, state_next;
    logic [CLOCK_W-1:0]       tone_clock_reg;
    logic [DURATION_BITS-1:0] remaining_reg, remaining_next;
    logic [RELOAD_W-1:0]      reload_reg, reload_next;
    logic [COMPARE_W-1:0]     compare_reg, compare_next;
    logic [PROD_W-1:0]        quo_reg, quo_next;
    logic [DIVISOR_W-1:0]     rem_reg, rem_next;
    logic [DIVISOR_W-1:0]     divisor_reg, divisor_next;
    logic [VCLAMP_W-1:0]      vol_reg, vol_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic [39:0]              m_data_reg, m_data_next;

    logic [FREQ_W-1:0]        in_freq;
    logic [DUR_W-1:0]         in_dur;
    logic [VOL_W-1:0]         in_vol;
    logic [ELAPSED_W-1:0]     in_elapsed;
    logic [FREQ_W-1:0]        freq_clamped;
    logic [VOL_W-1:0]         vol_clamped;
    logic [32:0]              dur_ext, elapsed_ext, remain_ext;
    logic [DURATION_BITS-1:0] dur_clamped, tick_remaining;

    logic [DIVISOR_W:0]       rem_shift;
    logic [DIVISOR_W:0]       rem_sub;
    logic                     rem_ge;
    logic [PROD_W-1:0]        product;

    logic                     in_fire;
    logic                     out_free;
    logic                     cfg_write;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_TONE_CLOCK) ? {8'd0, tone_clock_reg} : 32'd0;

    assign in_freq    = s_axis_tdata[15:0];
    assign in_dur     = s_axis_tdata[39:16];
    assign in_vol     = s_axis_tdata[47:40];
    assign in_elapsed = s_axis_tdata[63:48];

    always_comb
    begin
        if (in_freq < FREQ_MIN)
            freq_clamped = FREQ_MIN;
        else if (in_freq > FREQ_MAX)
            freq_clamped = FREQ_MAX;
        else
            freq_clamped = in_freq;

        vol_clamped = (in_vol > VOL_MAX) ? VOL_MAX : in_vol;

        dur_ext     = 33'(in_dur);
        dur_clamped = (dur_ext > DUR_MAX) ? DURATION_BITS'(DUR_MAX)
                                          : DURATION_BITS'(dur_ext);

        elapsed_ext    = 33'(in_elapsed);
        remain_ext     = 33'(remaining_reg);
        tick_remaining = (remain_ext > elapsed_ext)
                       ? DURATION_BITS'(remain_ext - elapsed_ext)
                       : '0;
    end

    // shared restoring divider step, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[PROD_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    end

    assign product = PROD_W'(quo_reg[RELOAD_W-1:0]) * PROD_W'(vol_reg);

    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        reload_next    = reload_reg;
        compare_next   = compare_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        vol_next       = vol_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DONE;
                    if (s_axis_tuser == OP_TICK)
                    begin
                        remaining_next = tick_remaining;
                        if (tick_remaining == '0)
                            compare_next = '0;
                    end
                    else if (in_dur != '0)
                    begin
                        remaining_next = dur_clamped;
                        quo_next       = {tone_clock_reg, {(PROD_W-CLOCK_W){1'b0}}};
                        rem_next       = '0;
                        divisor_next   = freq_clamped[DIVISOR_W-1:0];
                        vol_next       = vol_clamped[VCLAMP_W-1:0];
                        cnt_next       = CNT_W'(CLOCK_W - 1);
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_DIV, ST_DCMP:
            begin
                quo_next = {quo_reg[PROD_W-2:0], rem_ge};
                rem_next = rem_ge ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_DIV)
                        state_next = ST_MUL;
                    else
                    begin
                        compare_next = quo_next[COMPARE_W-1:0];
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                reload_next  = quo_reg[RELOAD_W-1:0];
                quo_next     = product;
                rem_next     = '0;
                divisor_next = DUTY_DIV;
                cnt_next     = CNT_W'(PROD_W - 1);
                state_next   = ST_DCMP;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, (remaining_reg != '0), compare_reg, reload_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tone_clock_reg <= RESET_CLOCK;
            remaining_reg  <= '0;
            reload_reg     <= RESET_RELOAD;
            compare_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            reload_reg    <= reload_next;
            compare_reg   <= compare_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_write && (paddr[2] == REG_TONE_CLOCK))
                tone_clock_reg <= pwdata[CLOCK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        vol_reg     <= vol_next;
        cnt_reg     <= cnt_next;
        m_data_reg  <= m_data_next;
    end

endmodule

`default_nettype wire
